[hw/rtl/ple_pkg.sv]
// shared constants, codes and types for the positional list engine
// no dependencies; imported by every module of the block
`default_nettype none

package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ACT_W  = 3;
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 8;

    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic step;
        logic emit;
    } ple_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go;
        logic last;
    } ple_sts_t;

endpackage

`default_nettype wire

[hw/rtl/ple_ctrl.sv]
// sequencing state machine of the positional list engine
// depends on ple_pkg; drives ple_dp through ple_cmd_t and reads ple_sts_t
`default_nettype none

module ple_ctrl
    import ple_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output ple_cmd_t      cmd,
    input  wire ple_sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load  = in_valid && (state_reg == S_IDLE);
        cmd.check = (state_reg == S_CHECK);
        cmd.step  = (state_reg == S_WALK);
        cmd.emit  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.go ? S_WALK : S_FINISH;
            end
            S_WALK:
            begin
                if (sts.last)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (cmd.emit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_CHECK)
        else $error("accepted word did not enter the check state");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

[hw/rtl/ple_dp.sv]
// datapath of the positional list engine: entry memory, walk pointers,
// bounds checks, result and output registers; depends on ple_pkg
`default_nettype none

module ple_dp
    import ple_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [POS_W-1:0]  position,
    input  wire data_t             value,
    input  wire ple_cmd_t          cmd,
    output ple_sts_t               sts,
    output logic      [STAT_W-1:0] status,
    output data_t                  read_value,
    output logic      [POS_W-1:0]  found_position,
    output logic      [LEN_W-1:0]  length
);

    data_t mem [CAPACITY];

    logic [ACT_W-1:0]  act_reg;
    logic [POS_W-1:0]  pos_reg;
    data_t             val_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  wlo_reg, wlo_next;
    logic [CNT_W-1:0]  whi_reg, whi_next;
    logic              pend_reg, pend_next;
    logic              ph_reg, ph_next;
    data_t             tmp_reg, tmp_next;
    data_t             rdata_reg;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    data_t             res_read_reg, res_read_next;
    logic [POS_W-1:0]  res_fp_reg, res_fp_next;
    logic [STAT_W-1:0] status_reg;
    data_t             read_value_reg;
    logic [POS_W-1:0]  found_position_reg;
    logic [LEN_W-1:0]  length_reg;

    logic [POS_W-1:0]  n_ext;
    logic [POS_W-1:0]  at;
    logic [CNT_W-1:0]  at_c;
    logic [STAT_W-1:0] chk_status;
    logic              chk_go;
    logic              match;
    logic              mem_we;
    logic [CNT_W-1:0]  mem_waddr;
    data_t             mem_wdata;
    logic              mem_re;
    logic [CNT_W-1:0]  mem_raddr;

    // positions 0 and 1 both mean the front
    assign n_ext = POS_W'(cnt_reg);
    assign at    = (pos_reg <= POS_W'(1)) ? '0 : pos_reg - POS_W'(1);
    assign at_c  = CNT_W'(at);
    assign match = pend_reg && (rdata_reg == val_reg);

    always_comb
    begin
        chk_status = ST_MISSING;
        chk_go     = 1'b0;
        unique case (act_reg)
            ACT_INSERT:
            begin
                if (at > n_ext)
                    chk_status = ST_MISSING;
                else if (cnt_reg >= CNT_W'(CAPACITY))
                    chk_status = ST_FULL;
                else
                begin
                    chk_status = ST_OK;
                    chk_go     = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                if (at < n_ext)
                begin
                    chk_status = ST_OK;
                    chk_go     = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (pos_reg >= POS_W'(1) && pos_reg <= n_ext)
                begin
                    chk_status = ST_OK;
                    chk_go     = 1'b1;
                end
            end
            ACT_FIND:
            begin
                // status turns ok only on a match
                chk_go = (cnt_reg != '0);
            end
            ACT_REVERSE:
            begin
                chk_status = ST_OK;
                chk_go     = (cnt_reg > CNT_W'(1));
            end
            default:
            begin
                chk_status = ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        wlo_next        = wlo_reg;
        whi_next        = whi_reg;
        pend_next       = pend_reg;
        ph_next         = ph_reg;
        tmp_next        = tmp_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_fp_next     = res_fp_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = val_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        sts.go          = chk_go;
        sts.last        = 1'b0;

        if (cmd.check)
        begin
            res_status_next = chk_status;
            res_read_next   = '0;
            res_fp_next     = '0;
            pend_next       = 1'b0;
            ph_next         = 1'b0;
            lo_next         = '0;
            hi_next         = cnt_reg - CNT_W'(1);
            if (act_reg == ACT_INSERT)
                rp_next = cnt_reg;
            else if (act_reg == ACT_DELETE)
                rp_next = at_c + CNT_W'(1);
            else
                rp_next = '0;
        end

        if (cmd.step)
        begin
            unique case (act_reg)
                ACT_INSERT:
                begin
                    // shift the tail up one place, last entry first
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wp_reg;
                        mem_wdata = rdata_reg;
                    end
                    if (rp_reg > at_c)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rp_reg - CNT_W'(1);
                        pend_next = 1'b1;
                        wp_next   = rp_reg;
                        rp_next   = rp_reg - CNT_W'(1);
                    end
                    else if (pend_reg)
                        pend_next = 1'b0;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = at_c;
                        mem_wdata = val_reg;
                        cnt_next  = cnt_reg + CNT_W'(1);
                        sts.last  = 1'b1;
                    end
                end
                ACT_DELETE:
                begin
                    // shift the tail down one place, front first
                    if (pend_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wp_reg;
                        mem_wdata = rdata_reg;
                    end
                    if (rp_reg < cnt_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rp_reg;
                        pend_next = 1'b1;
                        wp_next   = rp_reg - CNT_W'(1);
                        rp_next   = rp_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        cnt_next  = cnt_reg - CNT_W'(1);
                        sts.last  = 1'b1;
                    end
                end
                ACT_READ:
                begin
                    if (!pend_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = CNT_W'(pos_reg - POS_W'(1));
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        res_read_next = rdata_reg;
                        sts.last      = 1'b1;
                    end
                end
                ACT_FIND:
                begin
                    // compare lags the read: it uses the registered read data in the next cycle
                    if (match)
                    begin
                        res_status_next = ST_OK;
                        res_fp_next     = POS_W'(wp_reg) + POS_W'(1);
                        sts.last        = 1'b1;
                    end
                    else if (rp_reg < cnt_reg)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rp_reg;
                        pend_next = 1'b1;
                        wp_next   = rp_reg;
                        rp_next   = rp_reg + CNT_W'(1);
                    end
                    else
                        sts.last = 1'b1;
                end
                ACT_REVERSE:
                begin
                    // two phases per pair: read lo then hi; the writes of the
                    // previous pair overlap the reads of the next one
                    if (!ph_reg)
                    begin
                        if (pend_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = wlo_reg;
                            mem_wdata = rdata_reg;
                        end
                        if (lo_reg < hi_reg)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = lo_reg;
                        end
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = whi_reg;
                            mem_wdata = tmp_reg;
                        end
                        tmp_next = rdata_reg;
                        ph_next  = 1'b0;
                        if (lo_reg < hi_reg)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = hi_reg;
                            pend_next = 1'b1;
                            wlo_next  = lo_reg;
                            whi_next  = hi_reg;
                            lo_next   = lo_reg + CNT_W'(1);
                            hi_next   = hi_reg - CNT_W'(1);
                        end
                        else
                        begin
                            pend_next = 1'b0;
                            sts.last  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    sts.last = 1'b1;
                end
            endcase
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr[IDX_W-1:0]] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            pos_reg <= position;
            val_reg <= value;
        end
        rp_reg         <= rp_next;
        wp_reg         <= wp_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        wlo_reg        <= wlo_next;
        whi_reg        <= whi_next;
        tmp_reg        <= tmp_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_fp_reg     <= res_fp_next;
        if (cmd.emit)
        begin
            status_reg         <= res_status_reg;
            read_value_reg     <= res_read_reg;
            found_position_reg <= res_fp_reg;
            length_reg         <= LEN_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            ph_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            ph_reg   <= ph_next;
        end
    end

    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_position_reg;
    assign length         = length_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
        (cnt_reg == $past(cnt_reg) + CNT_W'(1) || cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same entry in one cycle");
`endif

endmodule

`default_nettype wire

[hw/rtl/positional_list_engine.sv]
// top level of the positional list engine: controller plus datapath
// depends on ple_pkg, ple_ctrl and ple_dp
//
// Bounded ordered list of up to CAPACITY signed 32-bit words with insert,
// delete, read, find and reverse requests; each accepted word yields exactly
// one result with status and the length after the request. The list lives in
// a single-port-read, single-port-write memory and a request walks it one
// entry per cycle, so the memory port sets the time per word: the request is
// accepted and bounds-checked; then, with index the zero-based place it
// points at, insert shifts the entries from index on up and writes the word
// at index, delete shifts the entries after index down, read fetches one
// entry, find scans from the front to a match or the end, reverse swaps
// pairs from both ends inward, and the result goes to the output register.
// A rejected request skips the walk. The next word is accepted while a
// finished result still waits in the output register.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [POS_W-1:0]  position,
    input  wire data_t             value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [STAT_W-1:0] status,
    output data_t                  read_value,
    output logic      [POS_W-1:0]  found_position,
    output logic      [LEN_W-1:0]  length
);

    ple_cmd_t cmd;
    ple_sts_t sts;

    ple_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ple_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .position       (position),
        .value          (value),
        .cmd            (cmd),
        .sts            (sts),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length)
    );

endmodule

`default_nettype wire

[verif/positional_list_engine_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for positional_list_engine: list predictor, result queue, drivers
// depends on ple_pkg and the positional_list_engine RTL

import ple_pkg::*;

typedef struct packed {
    logic [STAT_W-1:0] status;
    data_t             read_value;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  length;
} list_result_t;

class list_scoreboard;
    data_t        entries[CAPACITY];
    int unsigned  count;
    list_result_t pending_results[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  by_action[8];
    int unsigned  full_rejects;
    int unsigned  peak_length;

    function new();
        count        = 0;
        mismatches   = 0;
        checked      = 0;
        full_rejects = 0;
        peak_length  = 0;
        foreach (by_action[i])
            by_action[i] = 0;
    endfunction

    function int unsigned length();
        return count;
    endfunction

    function data_t entry_at(int unsigned idx);
        return entries[idx];
    endfunction

    function int unsigned pending();
        return pending_results.size();
    endfunction

    // update the list for one accepted word and queue its result
    function void apply_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, data_t val);
        list_result_t res;
        int unsigned  at;
        int unsigned  k;
        data_t        tmp;
        res        = '0;
        res.status = ST_MISSING;
        by_action[act]++;
        at = (pos <= 1) ? 0 : pos - 1;
        case (act)
            ACT_INSERT:
                // the position check wins over the full check
                if (at <= count)
                begin
                    if (count >= CAPACITY)
                    begin
                        res.status = ST_FULL;
                        full_rejects++;
                    end
                    else
                    begin
                        for (k = count; k > at; k--)
                            entries[k] = entries[k-1];
                        entries[at] = val;
                        count++;
                        res.status = ST_OK;
                    end
                end
            ACT_DELETE:
                if (at < count)
                begin
                    for (k = at; k + 1 < count; k++)
                        entries[k] = entries[k+1];
                    count--;
                    res.status = ST_OK;
                end
            ACT_READ:
                if (pos >= 1 && pos <= count)
                begin
                    res.read_value = entries[pos-1];
                    res.status     = ST_OK;
                end
            ACT_FIND:
                for (k = 0; k < count; k++)
                begin
                    if (entries[k] == val)
                    begin
                        res.found_position = POS_W'(k + 1);
                        res.status         = ST_OK;
                        break;
                    end
                end
            ACT_REVERSE:
            begin
                for (k = 0; k < count / 2; k++)
                begin
                    tmp                  = entries[k];
                    entries[k]           = entries[count-1-k];
                    entries[count-1-k]   = tmp;
                end
                res.status = ST_OK;
            end
            default:
                res.status = ST_MISSING;
        endcase
        res.length = LEN_W'(count);
        if (count > peak_length)
            peak_length = count;
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, data_t rd,
                               logic [POS_W-1:0] fp, logic [LEN_W-1:0] len);
        list_result_t want;
        checked++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with nothing pending: status %0d read %0d found %0d length %0d",
                         $realtime, st, rd, fp, len);
            return;
        end
        want = pending_results.pop_front();
        if (st !== want.status || rd !== want.read_value ||
            fp !== want.found_position || len !== want.length)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: mismatch on result %0d", $realtime, checked);
                $display("    expected status %0d read %0d found %0d length %0d",
                         want.status, want.read_value, want.found_position, want.length);
                $display("    actual   status %0d read %0d found %0d length %0d",
                         st, rd, fp, len);
            end
        end
    endfunction
endclass

module positional_list_engine_test;

    localparam int unsigned RANDOM_WORDS   = 780;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ACT_W-1:0]  action;
    logic [POS_W-1:0]  position;
    data_t             value;
    logic              out_valid;
    logic              out_stall;
    logic [STAT_W-1:0] status;
    data_t             read_value;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  length;

    list_scoreboard sb;
    int unsigned    tx_idle_pct;
    int unsigned    rx_stall_pct;
    int unsigned    tx_quiet;
    int unsigned    rx_quiet;
    int unsigned    idle_run;
    traffic_mode_t  mode;
    int unsigned    mode_left;
    data_t          value_pool[8];

    positional_list_engine DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .length         (length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle roll with occasional quiet stretches where nobody idles
    function automatic bit take_gap(int unsigned pct, inout int unsigned quiet);
        if (quiet != 0)
        begin
            quiet--;
            return 1'b0;
        end
        if ($urandom_range(99) < 3)
        begin
            quiet = $urandom_range(40, 8);
            return 1'b0;
        end
        return $urandom_range(99) < pct;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= take_gap(rx_stall_pct, rx_quiet);
    end

    // result check and watchdog, sampling values from before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(status, read_value, found_position, length);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d results pending",
                         $realtime, idle_run, sb.pending());
                $display("positional_list_engine_test: FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                             input data_t val);
        while (take_gap(tx_idle_pct, tx_quiet))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.apply_request(act, pos, val);
    endtask

    task automatic next_request(output logic [ACT_W-1:0] act, output logic [POS_W-1:0] pos,
                                output data_t val);
        int unsigned n;
        int unsigned roll;
        int unsigned ins_cut;
        int unsigned del_cut;
        n = sb.length();
        if (mode_left == 0)
        begin
            mode      = traffic_mode_t'($urandom_range(2));
            mode_left = $urandom_range(60, 20);
        end
        mode_left--;
        case (mode)
            MODE_GROW:   begin ins_cut = 60; del_cut = 68; end
            MODE_SHRINK: begin ins_cut = 15; del_cut = 60; end
            default:     begin ins_cut = 28; del_cut = 50; end
        endcase
        roll = $urandom_range(99);
        if (roll < ins_cut)
            act = ACT_INSERT;
        else if (roll < del_cut)
            act = ACT_DELETE;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                act = ACT_READ;
            else if (roll < 70)
                act = ACT_FIND;
            else if (roll < 92)
                act = ACT_REVERSE;
            else
                act = ACT_W'(ACT_REVERSE + $urandom_range(3, 1));
        end
        // mostly legal positions, some just past the end, some anywhere
        roll = $urandom_range(99);
        if (roll < 80)
            pos = POS_W'($urandom_range(n + 1, 0));
        else if (roll < 90)
            pos = POS_W'(n + $urandom_range(3, 0));
        else
            pos = POS_W'($urandom_range(255));
        roll = $urandom_range(99);
        if (act == ACT_FIND && n != 0 && roll < 60)
            val = sb.entry_at($urandom_range(n - 1, 0));
        else if (roll < 75)
            val = value_pool[$urandom_range(7)];
        else
            val = $urandom;
    endtask

    initial
    begin
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        data_t            val;

        sb            = new();
        value_pool[0] = 32'sd0;
        value_pool[1] = 32'sd1;
        value_pool[2] = -32'sd1;
        value_pool[3] = 32'sh7fffffff;
        value_pool[4] = 32'sh80000000;
        value_pool[5] = 32'sh55555555;
        value_pool[6] = 32'shaaaaaaaa;
        value_pool[7] = 32'sd42;
        tx_quiet      = 0;
        rx_quiet      = 0;
        idle_run      = 0;
        mode_left     = 0;
        mode          = MODE_GROW;
        tx_idle_pct   = 19;
        rx_stall_pct  = 88;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        out_stall <= 1'b0;
        action    <= ACT_INSERT;
        position  <= '0;
        value     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corners
        send_word(ACT_READ,    8'd0,   32'sd0);
        send_word(ACT_DELETE,  8'd1,   32'sd0);
        send_word(ACT_DELETE,  8'd0,   32'sd0);
        send_word(ACT_FIND,    8'd0,   32'sd0);
        send_word(ACT_REVERSE, 8'd0,   32'sd0);
        send_word(ACT_INSERT,  8'd2,   32'sd5);
        // single entry, then front and tail inserts
        send_word(ACT_INSERT,  8'd0,   32'sh7fffffff);
        send_word(ACT_REVERSE, 8'd0,   32'sd0);
        send_word(ACT_READ,    8'd1,   32'sd0);
        send_word(ACT_INSERT,  8'd1,   32'sh80000000);
        send_word(ACT_INSERT,  8'd3,   -32'sd1);
        send_word(ACT_INSERT,  8'd5,   32'sd9);
        send_word(ACT_INSERT,  8'd255, 32'sd9);
        send_word(ACT_READ,    8'd0,   32'sd0);
        send_word(ACT_READ,    8'd255, 32'sd0);
        send_word(ACT_READ,    8'd3,   32'sd0);
        send_word(ACT_FIND,    8'd0,   -32'sd1);
        send_word(ACT_FIND,    8'd0,   32'sd12345);
        send_word(ACT_REVERSE, 8'd0,   32'sd0);
        send_word(ACT_READ,    8'd1,   32'sd0);
        send_word(ACT_DELETE,  8'd0,   32'sd0);
        send_word(ACT_DELETE,  8'd5,   32'sd0);
        send_word(ACT_DELETE,  8'd2,   32'sd0);
        // codes past reverse do nothing
        send_word(ACT_REVERSE + 3'd1, 8'd255, -32'sd1);
        send_word(ACT_REVERSE + 3'd2, 8'd128, 32'sh7fffffff);
        send_word(ACT_REVERSE + 3'd3, 8'd1,   32'sh80000000);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 19; rx_stall_pct = 88; end
                1:       begin tx_idle_pct = 88; rx_stall_pct = 19; end
                default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            endcase
            repeat (RANDOM_WORDS / 3)
            begin
                next_request(act, pos, val);
                send_word(act, pos, val);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d insert, %0d delete, %0d read, %0d find, %0d reverse",
                 sb.checked, sb.by_action[ACT_INSERT], sb.by_action[ACT_DELETE],
                 sb.by_action[ACT_READ], sb.by_action[ACT_FIND], sb.by_action[ACT_REVERSE]);
        $display("unused codes %0d, list-full rejects %0d, peak length %0d, mismatches %0d",
                 sb.by_action[5] + sb.by_action[6] + sb.by_action[7], sb.full_rejects,
                 sb.peak_length, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("positional_list_engine_test: PASS");
        else
            $display("positional_list_engine_test: FAIL");
        $finish;
    end

endmodule
